@@ rtl/tdpt_pkg.sv @@
// Shared constants and handshake types for the trial-division primality tester.
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);

    localparam logic [VALUE_WIDTH-1:0] DIVISOR_THREE   = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] DIVISOR_FIVE    = VALUE_WIDTH'(5);
    localparam logic [VALUE_WIDTH-1:0] PAIR_OFFSET     = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] CANDIDATE_STEP  = VALUE_WIDTH'(6);
    localparam logic [VALUE_WIDTH-1:0] VALUE_ONE       = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] VALUE_THREE     = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] VALUE_FIVE      = VALUE_WIDTH'(5);

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [VALUE_WIDTH-1:0] remainder;
    } div_rsp_t;

endpackage

@@ rtl/tdpt_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module tdpt_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tdpt_pkg::div_req_t req,
    output tdpt_pkg::div_rsp_t rsp
);

    localparam int W  = tdpt_pkg::VALUE_WIDTH;
    localparam int CW = tdpt_pkg::COUNT_WIDTH;

    logic [W-1:0]  quo_reg,   quo_next;
    logic [W-1:0]  rem_reg,   rem_next;
    logic [W-1:0]  dvs_reg,   dvs_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          run_reg,   run_next;
    logic          done_reg,  done_next;
    logic [W+1:0]  diff;

    assign diff = {1'b0, rem_reg, quo_reg[W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[W-2:0], ~diff[W+1]};
            rem_next = diff[W+1] ? {rem_reg[W-2:0], quo_reg[W-1]} : diff[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/trial_division_primality_test.sv @@
// Top level: sequencer for the 6k plus or minus 1 trial-division primality test.
//
// A beat is taken when start is high and busy is low; one result beat follows,
// with is_prime valid in the single cycle that done is high. Numbers up to 5
// and even numbers answer in the cycle after the beat. Others go through one
// shared bit-serial divider: one test by 3 comes first, then each candidate
// pair (i, i + 2), with i from 5 in steps of 6, costs two divisions while
// i <= number / i. busy stays high while such a number is being tested;
// the result cannot be stalled.
module trial_division_primality_test
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0] number,
    output logic                             done,
    output logic                             is_prime
);

    localparam int W = tdpt_pkg::VALUE_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD3,
        ST_DIV_I,
        ST_DIV_I2
    } state_t;

    state_t        state_reg,     state_next;
    logic [W-1:0]  num_reg,       num_next;
    logic [W-1:0]  cand_reg,      cand_next;
    logic [W-1:0]  dvs_reg,       dvs_next;
    logic          dstart_reg,    dstart_next;
    logic          done_reg,      done_next;
    logic          prime_reg,     prime_next;

    tdpt_pkg::div_req_t div_req;
    tdpt_pkg::div_rsp_t div_rsp;
    logic               rem_zero;

    assign rem_zero = (div_rsp.remainder == '0);

    always_comb
    begin
        state_next  = state_reg;
        num_next    = num_reg;
        cand_next   = cand_reg;
        dvs_next    = dvs_reg;
        dstart_next = 1'b0;
        done_next   = 1'b0;
        prime_next  = prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next = number;
                    if (number <= tdpt_pkg::VALUE_ONE)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else if (number <= tdpt_pkg::VALUE_THREE || number == tdpt_pkg::VALUE_FIVE)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b1;
                    end
                    else if (!number[0])
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        dvs_next    = tdpt_pkg::DIVISOR_THREE;
                        dstart_next = 1'b1;
                        state_next  = ST_MOD3;
                    end
                end
            end
            ST_MOD3:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cand_next   = tdpt_pkg::DIVISOR_FIVE;
                        dvs_next    = tdpt_pkg::DIVISOR_FIVE;
                        dstart_next = 1'b1;
                        state_next  = ST_DIV_I;
                    end
                end
            end
            ST_DIV_I:
            begin
                if (div_rsp.done)
                begin
                    if (cand_reg > div_rsp.quotient)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (rem_zero)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dvs_next    = cand_reg + tdpt_pkg::PAIR_OFFSET;
                        dstart_next = 1'b1;
                        state_next  = ST_DIV_I2;
                    end
                end
            end
            ST_DIV_I2:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cand_next   = cand_reg + tdpt_pkg::CANDIDATE_STEP;
                        dvs_next    = cand_reg + tdpt_pkg::CANDIDATE_STEP;
                        dstart_next = 1'b1;
                        state_next  = ST_DIV_I;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            num_reg    <= '0;
            cand_reg   <= '0;
            dvs_reg    <= '0;
            dstart_reg <= 1'b0;
            done_reg   <= 1'b0;
            prime_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            num_reg    <= num_next;
            cand_reg   <= cand_next;
            dvs_reg    <= dvs_next;
            dstart_reg <= dstart_next;
            done_reg   <= done_next;
            prime_reg  <= prime_next;
        end
    end

    assign div_req.start    = dstart_reg;
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = dvs_reg;

    tdpt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

@@ dv/tb_trial_division_primality_test.sv @@
// Testbench for the trial-division primality tester against a local predictor.
module tb_trial_division_primality_test;

    localparam int VW             = tdpt_pkg::VALUE_WIDTH;
    localparam int NW             = 2 * VW;
    localparam int WATCHDOG_LIMIT = 4000000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          verdict;
    } prime_query_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [VW-1:0] number;
    logic          done;
    logic          is_prime;

    prime_query_t  pending_verdicts [$];
    int            mismatch_count = 0;

    trial_division_primality_test dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .number   (number),
        .done     (done),
        .is_prime (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic prime_verdict(input logic [VW-1:0] value);
        logic [NW-1:0] n;
        logic [NW-1:0] i;
        n = {{VW{1'b0}}, value};
        if (n <= 1)
            return 1'b0;
        if (n <= 3 || n == 5)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0 || n % 5 == 0)
            return 1'b0;
        for (i = NW'(5); i <= n / i; i += NW'(6))
        begin
            if (n % i == 0 || n % (i + NW'(2)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [VW-1:0] pick_number();
        logic [63:0] value;
        logic [63:0] factor;
        logic [63:0] ceiling;
        ceiling = 64'({VW{1'b1}});
        case ($urandom_range(9))
            0, 1, 2, 3: value = 64'($urandom_range(4095));
            4, 5:       value = 64'($urandom_range(1 << 20));
            6:
            begin
                factor = 64'($urandom_range(5, 1023) | 1);
                value  = factor * factor;
            end
            7:
            begin
                factor = 64'($urandom_range(5, 1021) | 1);
                value  = factor * (factor + 64'd2);
            end
            8:
            begin
                factor = 64'(6 * $urandom_range(1, 16));
                factor = $urandom_range(1) ? factor + 64'd1 : factor - 64'd1;
                value  = factor * 64'($urandom_range(0, 32'(ceiling / factor)));
            end
            default:
            begin
                value = 64'($urandom);
                value = $urandom_range(1) ? (value & ~64'd1) : value - value % 64'd3;
            end
        endcase
        return value[VW-1:0];
    endfunction

    task automatic send_number(input logic [VW-1:0] value);
        prime_query_t entry;
        @(negedge clk);
        start  = 1'b1;
        number = value;
        do
            @(posedge clk);
        while (busy);
        entry.value      = value;
        entry.verdict    = prime_verdict(value);
        pending_verdicts = {pending_verdicts, entry};
    endtask

    task automatic hold_off(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_trivial_numbers();
        logic [VW-1:0] values [8] = '{0, 1, 2, 3, 4, 5, 9, 35};
        foreach (values[k])
            send_number(values[k]);
    endtask

    task automatic test_loop_never_entered();
        logic [VW-1:0] values [3] = '{7, 13, 23};
        foreach (values[k])
            send_number(values[k]);
    endtask

    task automatic test_divisor_loop();
        logic [VW-1:0] values [7] = '{25, 49, 121, 143, 169, 65521, 1042441};
        foreach (values[k])
            send_number(values[k]);
    endtask

    task automatic test_field_extremes();
        logic [VW-1:0] values [5];
        values[0] = {VW{1'b1}};
        values[1] = {{(VW-1){1'b1}}, 1'b0};
        values[2] = {1'b1, {(VW-1){1'b0}}};
        values[3] = {(VW/2){2'b01}};
        values[4] = {(VW/2){2'b10}};
        foreach (values[k])
            send_number(values[k]);
    endtask

    task automatic test_random_numbers(input int count, input int idle_pct);
        repeat (count)
        begin
            hold_off(idle_pct);
            send_number(pick_number());
        end
    endtask

    always @(posedge clk)
    begin
        prime_query_t head;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: is_prime expected none, got %0b", is_prime);
            end
            else
            begin
                head = pending_verdicts.pop_front();
                if (is_prime !== head.verdict)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("number %0d: is_prime expected %0b, got %0b",
                                 head.value, head.verdict, is_prime);
                end
            end
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        number         = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_trivial_numbers();
        test_loop_never_entered();
        test_divisor_loop();
        test_field_extremes();
        test_random_numbers(28, 11);
        wait_for_results();
        test_random_numbers(27, 66);
        test_random_numbers(27, 0);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tdpt_pkg.sv
rtl/tdpt_div.sv
rtl/trial_division_primality_test.sv
dv/tb_trial_division_primality_test.sv
